[design/s128alu_pkg.sv]
// Shared constants and types for the signed 128-bit ALU.
`default_nettype none

package s128alu_pkg;

  localparam int WORD_W = 128;
  localparam int HALF_W = 64;
  localparam int KIND_W = 4;
  localparam int SH_W   = 8;
  localparam int CNT_W  = 7;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [KIND_W-1:0] KIND_ADD = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 4'd3;
  localparam logic [KIND_W-1:0] KIND_AND = 4'd4;
  localparam logic [KIND_W-1:0] KIND_OR  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_XOR = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SHL = 4'd7;
  localparam logic [KIND_W-1:0] KIND_SHR = 4'd8;
  localparam logic [KIND_W-1:0] KIND_NOT = 4'd9;

endpackage

`default_nettype wire

[design/signed_128bit_alu_unit.sv]
// Top level of the signed 128-bit ALU: sequencer around one shared 128-bit adder.
`default_nettype none

// Signed 128-bit ALU. An item is taken when start is high and busy is low; busy
// then stays high until the single result appears on the out_ ports for one
// cycle with out_valid high. The receiver cannot stall, so capture the result in
// that cycle. Add, subtract, logic ops and shifts go through S_EXEC and then to the
// result strobe. Multiply and divide pass S_ABS_A and S_ABS_B to form operand
// magnitudes, 128 shift-add or restoring-subtract steps in S_LOOP, and S_SIGN
// to apply the sign; every step goes through the same 128-bit adder. A new item
// may be started in the cycle the result is shown.
module signed_128bit_alu_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [s128alu_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [s128alu_pkg::HALF_W-1:0] in_a_hi,
  input  logic [s128alu_pkg::HALF_W-1:0]        in_a_lo,
  input  logic signed [s128alu_pkg::HALF_W-1:0] in_b_hi,
  input  logic [s128alu_pkg::HALF_W-1:0]        in_b_lo,
  input  logic [s128alu_pkg::SH_W-1:0]          in_shift_amount,
  output logic                                  out_valid,
  output logic signed [s128alu_pkg::HALF_W-1:0] out_result_hi,
  output logic [s128alu_pkg::HALF_W-1:0]        out_result_lo,
  output logic                                  out_overflow
);

  localparam int W  = s128alu_pkg::WORD_W;
  localparam int HW = s128alu_pkg::HALF_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ABS_A = 3'd2;
  localparam logic [2:0] S_ABS_B = 3'd3;
  localparam logic [2:0] S_LOOP  = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;

  localparam logic [s128alu_pkg::CNT_W-1:0] CNT_LAST = {s128alu_pkg::CNT_W{1'b1}};

  logic [2:0]                       state_r, state_nxt;
  logic [s128alu_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [s128alu_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [s128alu_pkg::SH_W-1:0]     sh_r, sh_nxt;
  s128alu_pkg::word_t               a_r, a_nxt;
  s128alu_pkg::word_t               b_r, b_nxt;
  s128alu_pkg::word_t               acc_r, acc_nxt;
  s128alu_pkg::word_t               q_r, q_nxt;
  logic                             neg_r, neg_nxt;
  logic                             out_valid_r, out_valid_nxt;
  s128alu_pkg::word_t               res_r, res_nxt;
  logic                             ovf_r, ovf_nxt;

  // shared adder
  s128alu_pkg::word_t add_x, add_y;
  logic               add_ci;
  logic [W:0]         sum;

  s128alu_pkg::word_t div_c;
  s128alu_pkg::word_t shl_v;
  logic               is_div;

  assign sum    = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_ci};
  assign is_div = (kind_r == s128alu_pkg::KIND_DIV);
  assign div_c  = {acc_r[W-2:0], q_r[W-1]};
  assign shl_v  = a_r << sh_r;

  always_comb begin
    add_x  = a_r;
    add_y  = b_r;
    add_ci = 1'b0;
    case (state_r)
      S_EXEC: begin
        add_x  = a_r;
        add_y  = (kind_r == s128alu_pkg::KIND_SUB) ? ~b_r : b_r;
        add_ci = (kind_r == s128alu_pkg::KIND_SUB);
      end
      S_ABS_A: begin
        add_x  = ~a_r;
        add_y  = '0;
        add_ci = 1'b1;
      end
      S_ABS_B: begin
        add_x  = ~b_r;
        add_y  = '0;
        add_ci = 1'b1;
      end
      S_LOOP: begin
        if (is_div) begin
          add_x  = div_c;
          add_y  = ~b_r;
          add_ci = 1'b1;
        end else begin
          add_x  = acc_r;
          add_y  = q_r[0] ? a_r : '0;
          add_ci = 1'b0;
        end
      end
      S_SIGN: begin
        add_x  = ~q_r;
        add_y  = '0;
        add_ci = 1'b1;
      end
      default: begin
        add_x  = a_r;
        add_y  = b_r;
        add_ci = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    sh_nxt        = sh_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    ovf_nxt       = ovf_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          sh_nxt   = in_shift_amount;
          a_nxt    = {in_a_hi, in_a_lo};
          b_nxt    = {in_b_hi, in_b_lo};
          neg_nxt  = in_a_hi[HW-1] ^ in_b_hi[HW-1];
          cnt_nxt  = '0;
          if (in_kind == s128alu_pkg::KIND_MUL || in_kind == s128alu_pkg::KIND_DIV) begin
            state_nxt = S_ABS_A;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        ovf_nxt = 1'b0;
        case (kind_r)
          s128alu_pkg::KIND_ADD: begin
            res_nxt = sum[W-1:0];
            ovf_nxt = (a_r[W-1] == b_r[W-1]) && (sum[W-1] != a_r[W-1]);
          end
          s128alu_pkg::KIND_SUB: begin
            res_nxt = sum[W-1:0];
            ovf_nxt = (a_r[W-1] != b_r[W-1]) && (sum[W-1] != a_r[W-1]);
          end
          s128alu_pkg::KIND_AND: res_nxt = a_r & b_r;
          s128alu_pkg::KIND_OR:  res_nxt = a_r | b_r;
          s128alu_pkg::KIND_XOR: res_nxt = a_r ^ b_r;
          s128alu_pkg::KIND_NOT: res_nxt = ~a_r;
          // keep the sign bit in place after the shift
          s128alu_pkg::KIND_SHL: res_nxt = {a_r[W-1], shl_v[W-2:0]};
          s128alu_pkg::KIND_SHR: res_nxt = s128alu_pkg::word_t'($signed(a_r) >>> sh_r);
          default: res_nxt = '0;
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ABS_A: begin
        if (a_r[W-1]) begin
          a_nxt = sum[W-1:0];
        end
        state_nxt = S_ABS_B;
      end
      S_ABS_B: begin
        // load the loop registers from the magnitudes
        if (is_div) begin
          b_nxt   = b_r[W-1] ? sum[W-1:0] : b_r;
          q_nxt   = a_r;
          acc_nxt = {W{a_r[W-1]}};
        end else begin
          q_nxt   = b_r[W-1] ? sum[W-1:0] : b_r;
          acc_nxt = '0;
        end
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (is_div) begin
          if (!sum[W-1]) begin
            acc_nxt = sum[W-1:0];
            q_nxt   = {q_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = div_c;
            q_nxt   = {q_r[W-2:0], 1'b0};
          end
        end else begin
          acc_nxt = sum[W:1];
          q_nxt   = {sum[0], q_r[W-1:1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        res_nxt = neg_r ? sum[W-1:0] : q_r;
        if (is_div) begin
          ovf_nxt = 1'b0;
        end else if (|acc_r) begin
          ovf_nxt = 1'b1;
        end else if (neg_r) begin
          ovf_nxt = q_r[W-1] && (|q_r[W-2:0]);
        end else begin
          ovf_nxt = q_r[W-1];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    sh_r   <= sh_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_result_hi = res_r[W-1:HW];
  assign out_result_lo = res_r[HW-1:0];
  assign out_overflow  = ovf_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid_r))
    else $error("accepted item did not raise busy");

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP && cnt_r == CNT_LAST) |=> (state_r == S_SIGN))
    else $error("iteration loop did not end after the last step");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while still busy");

endmodule

`default_nettype wire

[verif/alu_result_checker.sv]
// Checker for the signed 128-bit ALU: predicts each accepted item and compares the result strobe.
module alu_result_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [s128alu_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [s128alu_pkg::HALF_W-1:0] in_a_hi,
  input  logic [s128alu_pkg::HALF_W-1:0]        in_a_lo,
  input  logic signed [s128alu_pkg::HALF_W-1:0] in_b_hi,
  input  logic [s128alu_pkg::HALF_W-1:0]        in_b_lo,
  input  logic [s128alu_pkg::SH_W-1:0]          in_shift_amount,
  input  logic                                  out_valid,
  input  logic signed [s128alu_pkg::HALF_W-1:0] out_result_hi,
  input  logic [s128alu_pkg::HALF_W-1:0]        out_result_lo,
  input  logic                                  out_overflow,
  output int                                    mismatch_count,
  output int                                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import s128alu_pkg::*;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [HALF_W-1:0] hi;
    logic [HALF_W-1:0]        lo;
    logic                     ovf;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic word_t magnitude(word_t x);
    magnitude = x[WORD_W-1] ? -x : x;
  endfunction

  function automatic alu_result_t predict_alu(logic [KIND_W-1:0] kind, word_t a, word_t b,
                                              logic [SH_W-1:0] sh);
    alu_result_t r;
    word_t w, ma, mb, q, c, d, s;
    logic [2*WORD_W-1:0] prod;
    logic neg;
    int i;
    r.kind = kind;
    r.ovf = 1'b0;
    w = '0;
    neg = a[WORD_W-1] ^ b[WORD_W-1];
    case (kind)
      KIND_ADD: begin
        w = a + b;
        r.ovf = (a[WORD_W-1] == b[WORD_W-1]) && (w[WORD_W-1] != a[WORD_W-1]);
      end
      KIND_SUB: begin
        w = a - b;
        r.ovf = (a[WORD_W-1] != b[WORD_W-1]) && (w[WORD_W-1] != a[WORD_W-1]);
      end
      KIND_MUL: begin
        ma = magnitude(a);
        mb = magnitude(b);
        prod = {{WORD_W{1'b0}}, ma} * {{WORD_W{1'b0}}, mb};
        if (prod[2*WORD_W-1:WORD_W] != '0)
          r.ovf = 1'b1;
        else if (neg)
          r.ovf = prod[WORD_W-1:0] > {1'b1, {(WORD_W-1){1'b0}}};
        else
          r.ovf = prod[WORD_W-1];
        w = prod[WORD_W-1:0];
        if (neg) w = -w;
      end
      KIND_DIV: begin
        // restoring division on magnitudes; the most negative dividend starts from all ones
        q = magnitude(a);
        d = magnitude(b);
        c = {WORD_W{q[WORD_W-1]}};
        for (i = 0; i < WORD_W; i++) begin
          {c, q} = {c, q} << 1;
          s = c - d;
          if (!s[WORD_W-1]) begin
            c = s;
            q[0] = 1'b1;
          end
        end
        w = neg ? -q : q;
      end
      KIND_AND: w = a & b;
      KIND_OR:  w = a | b;
      KIND_XOR: w = a ^ b;
      KIND_SHL: begin
        w = (sh >= WORD_W) ? '0 : (a << sh);
        w[WORD_W-1] = a[WORD_W-1];
      end
      KIND_SHR: w = (sh >= WORD_W) ? {WORD_W{a[WORD_W-1]}} : word_t'($signed(a) >>> sh);
      KIND_NOT: w = ~a;
      default:  w = '0;
    endcase
    r.hi = w[WORD_W-1:HALF_W];
    r.lo = w[HALF_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n) begin
      // compare first: a result never belongs to the item taken at the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no item outstanding: hi=%h lo=%h ovf=%b",
                     $realtime, out_result_hi, out_result_lo, out_overflow);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_result_hi !== exp_r.hi || out_result_lo !== exp_r.lo ||
              out_overflow !== exp_r.ovf) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: kind %0d mismatch: expected hi=%h lo=%h ovf=%b, ",
                        "got hi=%h lo=%h ovf=%b"},
                       $realtime, exp_r.kind, exp_r.hi, exp_r.lo, exp_r.ovf,
                       out_result_hi, out_result_lo, out_overflow);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_alu(in_kind, {in_a_hi, in_a_lo},
                                               {in_b_hi, in_b_lo}, in_shift_amount));
    end
    results_owed = expected_results.size();
  end

endmodule

[verif/signed_128bit_alu_unit_tb.sv]
// Testbench top for the signed 128-bit ALU: clock, reset, item stimulus and verdict.
module signed_128bit_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s128alu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  localparam word_t W_ONE = word_t'(1);
  localparam word_t W_ALL = {WORD_W{1'b1}};
  localparam word_t W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam int N_RANDOM = 550;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [HALF_W-1:0] in_a_hi = '0;
  logic [HALF_W-1:0]        in_a_lo = '0;
  logic signed [HALF_W-1:0] in_b_hi = '0;
  logic [HALF_W-1:0]        in_b_lo = '0;
  logic [SH_W-1:0]          in_shift_amount = '0;
  logic                     out_valid;
  logic signed [HALF_W-1:0] out_result_hi;
  logic [HALF_W-1:0]        out_result_lo;
  logic                     out_overflow;
  int                       mismatch_count;
  int                       results_owed;

  signed_128bit_alu_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_a_hi         (in_a_hi),
    .in_a_lo         (in_a_lo),
    .in_b_hi         (in_b_hi),
    .in_b_lo         (in_b_lo),
    .in_shift_amount (in_shift_amount),
    .out_valid       (out_valid),
    .out_result_hi   (out_result_hi),
    .out_result_lo   (out_result_lo),
    .out_overflow    (out_overflow)
  );

  alu_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_a_hi         (in_a_hi),
    .in_a_lo         (in_a_lo),
    .in_b_hi         (in_b_hi),
    .in_b_lo         (in_b_lo),
    .in_shift_amount (in_shift_amount),
    .out_valid       (out_valid),
    .out_result_hi   (out_result_hi),
    .out_result_lo   (out_result_lo),
    .out_overflow    (out_overflow),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Present one item and hold it until the edge that takes it; returns at that edge.
  task automatic send_item(logic [KIND_W-1:0] kind, word_t a, word_t b, logic [SH_W-1:0] sh);
    logic was_busy;
    in_kind         <= kind;
    in_a_hi         <= a[WORD_W-1:HALF_W];
    in_a_lo         <= a[HALF_W-1:0];
    in_b_hi         <= b[WORD_W-1:HALF_W];
    in_b_lo         <= b[HALF_W-1:0];
    in_shift_amount <= sh;
    start           <= 1'b1;
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  function automatic word_t rand_operand();
    word_t x;
    x = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 7))
      1: x = word_t'($urandom_range(0, 255));
      2: x = -word_t'($urandom_range(1, 255));
      3: x = {{HALF_W{x[HALF_W-1]}}, x[HALF_W-1:0]};
      4: begin
        case ($urandom_range(0, 4))
          0:       x = '0;
          1:       x = W_ONE;
          2:       x = W_ALL;
          3:       x = W_MAX;
          default: x = W_MIN;
        endcase
      end
      5: begin
        x = W_ONE << $urandom_range(0, WORD_W-1);
        if ($urandom_range(0, 1)) x = -x;
      end
      6: x = $signed(x) >>> $urandom_range(0, WORD_W-2);
      default: ;
    endcase
    return x;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 24) == 0)
      return KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    return KIND_W'($urandom_range(KIND_NOT, KIND_ADD));
  endfunction

  function automatic logic [SH_W-1:0] pick_shift();
    // lean on the counts around the word width
    if ($urandom_range(0, 3) == 0) return SH_W'($urandom_range(WORD_W+7, WORD_W-8));
    return SH_W'($urandom_range(255, 0));
  endfunction

  initial begin
    int burst_left;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_ADD, W_MAX, W_ONE, 8'd0);
    send_item(KIND_ADD, W_MIN, W_MIN, 8'd0);
    send_item(KIND_SUB, W_MIN, W_ONE, 8'd0);
    send_item(KIND_SUB, '0, W_MIN, 8'd0);
    send_item(KIND_MUL, W_MAX, W_MAX, 8'd0);
    send_item(KIND_MUL, W_MIN, W_ONE, 8'd0);
    send_item(KIND_MUL, W_MIN, W_ALL, 8'd0);
    send_item(KIND_MUL, W_ONE << 64, W_ONE << 63, 8'd0);
    send_item(KIND_DIV, W_MIN, W_ALL, 8'd0);
    send_item(KIND_DIV, W_MAX, '0, 8'd0);
    send_item(KIND_DIV, W_MIN, W_MIN, 8'd0);
    send_item(KIND_DIV, word_t'(7), -word_t'(2), 8'd0);
    send_item(KIND_AND, W_ALL, W_MIN, 8'd0);
    send_item(KIND_OR, W_MIN, W_ONE, 8'd0);
    send_item(KIND_XOR, W_ALL, W_MAX, 8'd0);
    send_item(KIND_NOT, W_MIN, W_ALL, 8'd0);
    send_item(KIND_SHL, W_MIN | W_ONE, '0, 8'd0);
    send_item(KIND_SHL, W_ALL, '0, 8'd127);
    send_item(KIND_SHL, W_MAX, '0, 8'd128);
    send_item(KIND_SHL, W_ALL, '0, 8'd255);
    send_item(KIND_SHR, W_MIN, '0, 8'd0);
    send_item(KIND_SHR, W_MIN, '0, 8'd64);
    send_item(KIND_SHR, W_MIN, '0, 8'd127);
    send_item(KIND_SHR, W_MAX, '0, 8'd128);
    send_item(KIND_UNUSED_HI, W_ALL, W_ALL, 8'd255);
    wait_drained();

    burst_left = $urandom_range(1, 10);
    for (int n = 0; n < N_RANDOM; n++) begin
      send_item(pick_kind(), rand_operand(), rand_operand(), pick_shift());
      if (n == N_RANDOM / 2) begin
        wait_drained();
      end else if (--burst_left == 0) begin
        // idle for a while with junk on the item ports
        start           <= 1'b0;
        in_kind         <= KIND_W'($urandom);
        in_a_hi         <= {$urandom, $urandom};
        in_b_lo         <= {$urandom, $urandom};
        in_shift_amount <= SH_W'($urandom);
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      end
    end

    wait_drained();
    repeat (140) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
